### rtl/rfz_pkg.sv
// ----------------------------------------------------------------------------
// rfz_pkg
// Shared types and constants of the zero-padded row FIR filter.
// ----------------------------------------------------------------------------
package rfz_pkg;

  // Kernel geometry
  localparam int unsigned MaxTaps  = 7;
  localparam int unsigned WinDepth = MaxTaps - 1;

  // Field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned TapsW  = 3;
  localparam int unsigned ProdW  = CoefW + PixW;   // signed coef times unsigned pixel
  localparam int unsigned SumW   = 27;
  localparam int unsigned LagW   = 2;               // lag is at most 3
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTaps  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoef0 = 3'd1;

  // Reset values
  localparam logic [TapsW-1:0] TapsReset = 3'd5;
  localparam int unsigned      CoefUnityTap = 2;

  typedef logic [MaxTaps-1:0][CoefW-1:0] coef_vec_t;
  typedef logic [MaxTaps-1:0][ProdW-1:0] prod_vec_t;

  // All weights zero except a unit weight on the center tap
  localparam coef_vec_t CoefReset = coef_vec_t'(1) << (CoefUnityTap * CoefW);

  // Product beat handed from the window stage to the adder stage
  typedef struct packed {
    logic      valid;
    logic      last;
    prod_vec_t prod;
  } prod_beat_t;

endpackage

### rtl/row_fir_zero_padded_top.sv
// ----------------------------------------------------------------------------
// row_fir_zero_padded_top
// Centered FIR over image rows with zero padding at both row ends.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, tlast on the last
//   pixel of a row. Filtered columns leave on m_axis in column order, tlast
//   on the final column of the row. Taps and coefficients are written on the
//   cfg port while the stream is idle.
//   With T active taps the output trails the input by L = T-1-T/2 pixels.
//   A result beat passes the product register and then the adder register.
//   One pixel is taken per cycle while m_axis does not stall; after a row's
//   last pixel the input stalls while the owed columns, up to L of them, are
//   flushed with zero padding. The cost per beat is set by the seven tap
//   multipliers feeding one adder register.
//   Reset clears the window, the lag and flush counters and the valid flags of
//   both pipeline registers, and loads T=5 with a unit weight on tap 2.
//   When m_axis stalls, the product register still fills, after which
//   s_axis_tready drops until the output beat is taken.
// ----------------------------------------------------------------------------
module row_fir_zero_padded_top
  import rfz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  // Pixel input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] pixel
  input  logic               s_axis_tlast,   // row_end
  // Filtered output
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [26:0] filtered, [31:27] zero
  output logic               m_axis_tlast    // last_of_row
);

  logic [TapsW-1:0] taps_q;
  coef_vec_t        coef_q;
  prod_beat_t       beat;
  logic             adv;
  logic [SumW-1:0]  sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TapsReset;
      coef_q <= CoefReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTaps) begin
        taps_q <= cfg_data_i[TapsW-1:0];
      end else begin
        coef_q[cfg_idx_i - CfgCoef0] <= cfg_data_i;
      end
    end
  end

  rfz_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .taps_i     (taps_q),
    .coef_i     (coef_q),
    .in_valid_i (s_axis_tvalid),
    .in_pixel_i (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .adv_i      (adv),
    .beat_o     (beat)
  );

  rfz_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (sum),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, sum};

endmodule

### rtl/rfz_window.sv
// ----------------------------------------------------------------------------
// rfz_window
// Pixel window, lag and flush control, tap products and the product register.
// ----------------------------------------------------------------------------
module rfz_window
  import rfz_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TapsW-1:0] taps_i,
  input  coef_vec_t        coef_i,
  input  logic             in_valid_i,
  input  logic [PixW-1:0]  in_pixel_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             adv_i,       // adder stage takes the product beat
  output prod_beat_t       beat_o
);

  logic [WinDepth-1:0][PixW-1:0] win_q, win_d;
  logic [LagW-1:0]               elag_q, elag_d;
  logic [LagW-1:0]               flush_q, flush_d;
  logic                          bvalid_q;
  logic                          blast_q;
  prod_vec_t                     bprod_q;
  prod_beat_t                    beat_d;

  logic [TapsW-1:0]              t_act;
  logic [TapsW-1:0]              lag_full;
  logic [LagW-1:0]               lag;
  logic [LagW-1:0]               e_cl;
  logic [LagW-1:0]               e_new;
  logic                          flushing;
  logic                          slot_free;
  logic                          fire;
  logic                          emit;
  logic                          last;
  logic                          clear_win;
  logic [MaxTaps-1:0][PixW-1:0]  taps_buf;
  prod_vec_t                     prod;

  // Active tap count and output lag
  assign t_act    = (taps_i == '0) ? TapsW'(1) : taps_i;
  assign lag_full = t_act - TapsW'(1) - (t_act >> 1);
  assign lag      = lag_full[LagW-1:0];

  assign flushing   = (flush_q != '0);
  assign slot_free  = !bvalid_q || adv_i;
  assign fire       = slot_free && (flushing || in_valid_i);
  assign in_ready_o = slot_free && !flushing;

  // Owed count clamped to the current lag
  assign e_cl  = (elag_q > lag) ? lag : elag_q;
  assign emit  = flushing || (e_cl == lag);
  assign e_new = emit ? e_cl : e_cl + LagW'(1);

  // Window after the shift, newest first; zeros are fed while flushing
  always_comb begin
    taps_buf[0] = flushing ? '0 : in_pixel_i;
    for (int j = 1; j < MaxTaps; j++) begin
      taps_buf[j] = win_q[j-1];
    end
  end

  // Tap products: coef i meets the pixel T-1-i places back
  always_comb begin
    logic [TapsW-1:0]         k;
    logic signed [ProdW:0]    p;
    for (int i = 0; i < MaxTaps; i++) begin
      k = t_act - TapsW'(1) - TapsW'(i);
      p = $signed(coef_i[i]) * $signed({1'b0, taps_buf[k]});
      prod[i] = (TapsW'(i) < t_act) ? p[ProdW-1:0] : '0;
    end
  end

  // Next control state
  always_comb begin
    elag_d    = elag_q;
    flush_d   = flush_q;
    last      = 1'b0;
    clear_win = 1'b0;
    if (flushing) begin
      flush_d   = flush_q - LagW'(1);
      last      = (flush_q == LagW'(1));
      clear_win = (flush_q == LagW'(1));
    end else begin
      last = in_last_i && (lag == '0);
      if (in_last_i) begin
        elag_d    = '0;
        flush_d   = e_new;
        clear_win = (e_new == '0);
      end else begin
        elag_d = e_new;
      end
    end

    win_d = win_q;
    if (clear_win) begin
      win_d = '0;
    end else begin
      for (int j = 0; j < WinDepth; j++) begin
        win_d[j] = taps_buf[j];
      end
    end

    beat_d = '{valid: 1'b0, last: blast_q, prod: bprod_q};
    if (fire) begin
      beat_d.valid = emit;
      beat_d.last  = last;
      beat_d.prod  = prod;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      elag_q   <= '0;
      flush_q  <= '0;
      bvalid_q <= 1'b0;
    end else begin
      if (fire) begin
        win_q   <= win_d;
        elag_q  <= elag_d;
        flush_q <= flush_d;
      end
      if (slot_free) begin
        bvalid_q <= beat_d.valid;
      end
    end
  end

  // Product payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      blast_q <= beat_d.last;
      bprod_q <= beat_d.prod;
    end
  end

  assign beat_o = '{valid: bvalid_q, last: blast_q, prod: bprod_q};

endmodule

### rtl/rfz_sum.sv
// ----------------------------------------------------------------------------
// rfz_sum
// Adds the tap products and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module rfz_sum
  import rfz_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prod_beat_t      beat_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SumW-1:0] out_sum_o,
  output logic            out_last_o
);

  logic            valid_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic            last_q;

  assign adv_o = !valid_q || out_ready_i;

  // Sign-extend and add the products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MaxTaps; i++) begin
      sum_d = sum_d + SumW'($signed(beat_i.prod[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && beat_i.valid) begin
      sum_q  <= sum_d;
      last_q <= beat_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sum_o   = sum_q;
  assign out_last_o  = last_q;

endmodule
